/* src/rlps_pkg.sv */
// Shared types and constants for the addressable RGB LED line serializer.
`timescale 1ns / 1ps
`default_nettype none

package rlps_pkg;

   // Pixel store depth and derived widths
   localparam int MAX_LEDS = 256;
   localparam int LED_W    = $clog2(MAX_LEDS);
   localparam int N_W      = $clog2(MAX_LEDS + 1);
   localparam int BYTE_W   = $clog2(3 * MAX_LEDS + 1);

   // Pixel word: green, red, blue from the top byte down
   localparam int PIXEL_W  = 24;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_LED_COUNT = 3'd0;
   localparam logic [2:0] REG_ZERO_HIGH = 3'd1;
   localparam logic [2:0] REG_ZERO_LOW  = 3'd2;
   localparam logic [2:0] REG_ONE_HIGH  = 3'd3;
   localparam logic [2:0] REG_ONE_LOW   = 3'd4;
   localparam logic [2:0] REG_GAP       = 3'd5;

   localparam logic [8:0]  RST_LED_COUNT = 9'd0;
   localparam logic [7:0]  RST_ZERO_HIGH = 8'd4;
   localparam logic [7:0]  RST_ZERO_LOW  = 8'd9;
   localparam logic [7:0]  RST_ONE_HIGH  = 8'd8;
   localparam logic [7:0]  RST_ONE_LOW   = 8'd5;
   localparam logic [15:0] RST_GAP       = 16'd800;

   // Command codes carried in the mode field
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_SET   = 3'd1;
   localparam logic [2:0] MODE_FILL  = 3'd2;
   localparam logic [2:0] MODE_CLEAR = 3'd3;
   localparam logic [2:0] MODE_SHOW  = 3'd4;

   // Byte within the current pixel
   localparam logic [1:0] PART_GREEN = 2'd0;
   localparam logic [1:0] PART_RED   = 2'd1;
   localparam logic [1:0] PART_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_LOAD_FIRST,
      ST_LOAD_PIXEL,
      ST_FILL
   } ctrl_state_type;

   typedef struct packed {
      logic [8:0]  led_count;
      logic [7:0]  zero_high;
      logic [7:0]  zero_low;
      logic [7:0]  one_high;
      logic [7:0]  one_low;
      logic [15:0] gap;
   } cfg_type;

   typedef struct packed {
      logic take_item;
      logic load_first;
      logic load_pixel;
      logic fill_step;
   } cmd_type;

   typedef struct packed {
      logic sending;
      logic n_zero;
      logic fill_last;
   } status_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
      logic rejected;
   } result_type;

endpackage

`default_nettype wire

/* src/rlps_csr.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module rlps_csr
   import rlps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_strobe;

   assign reg_idx   = csr_paddr[4:2];
   assign wr_strobe = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_LED_COUNT: cfg_in.led_count = csr_pwdata[8:0];
            REG_ZERO_HIGH: cfg_in.zero_high = csr_pwdata[7:0];
            REG_ZERO_LOW:  cfg_in.zero_low  = csr_pwdata[7:0];
            REG_ONE_HIGH:  cfg_in.one_high  = csr_pwdata[7:0];
            REG_ONE_LOW:   cfg_in.one_low   = csr_pwdata[7:0];
            REG_GAP:       cfg_in.gap       = csr_pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LED_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.led_count);
         REG_ZERO_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.zero_high);
         REG_ZERO_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.zero_low);
         REG_ONE_HIGH:  csr_prdata = CSR_DATA_W'(cfg_ff.one_high);
         REG_ONE_LOW:   csr_prdata = CSR_DATA_W'(cfg_ff.one_low);
         REG_GAP:       csr_prdata = CSR_DATA_W'(cfg_ff.gap);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count <= RST_LED_COUNT;
         cfg_ff.zero_high <= RST_ZERO_HIGH;
         cfg_ff.zero_low  <= RST_ZERO_LOW;
         cfg_ff.one_high  <= RST_ONE_HIGH;
         cfg_ff.one_low   <= RST_ONE_LOW;
         cfg_ff.gap       <= RST_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* src/rlps_ctrl.sv */
// Controller state machine: transaction acceptance, store read-in and fill sweep.
`timescale 1ns / 1ps
`default_nettype none

module rlps_ctrl
   import rlps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_mode,
   input  wire logic       out_free,
   input  wire status_type status,
   output      logic       req_ready,
   output      cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (cmd.take_item && !status.sending) begin
               if (req_mode == MODE_SHOW) begin
                  state_in = ST_LOAD_FIRST;
               end else if (req_mode == MODE_FILL && !status.n_zero) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_LOAD_FIRST: state_in = ST_LOAD_PIXEL;
         ST_LOAD_PIXEL: state_in = ST_RUN;
         ST_FILL: begin
            if (status.fill_last) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_RUN) && out_free;
      cmd.take_item  = req_ready && req_valid;
      cmd.load_first = (state_ff == ST_LOAD_FIRST);
      cmd.load_pixel = (state_ff == ST_LOAD_PIXEL);
      cmd.fill_step  = (state_ff == ST_FILL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* src/rlps_dp.sv */
// Datapath: pixel store, bit timing counters and line waveform generation.
`timescale 1ns / 1ps
`default_nettype none

module rlps_dp
   import rlps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire cfg_type    cfg,
   input  wire logic [2:0] req_mode,
   input  wire logic [7:0] req_pixel_index,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output      status_type status,
   output      result_type res
);

   // Pixel store; entries without a valid flag read as zero
   logic [PIXEL_W-1:0]  store_mem [MAX_LEDS];
   logic [MAX_LEDS-1:0] valid_ff;
   logic [PIXEL_W-1:0]  rd_data_ff;
   logic                rd_valid_ff;
   logic [PIXEL_W-1:0]  rd_word;
   logic [LED_W-1:0]    rd_addr;

   logic                wr_en;
   logic [LED_W-1:0]    wr_addr;
   logic [PIXEL_W-1:0]  wr_data;
   logic                valid_clr;

   // Frame state
   logic              sending_ff, sending_in;
   logic              gap_ff, gap_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [2:0]        bit_ff, bit_in;
   logic              low_ff, low_in;
   logic [15:0]       tick_ff, tick_in;
   logic [7:0]        shift_ff, shift_in;
   logic [PIXEL_W-1:0] cur_ff, cur_in;
   logic [LED_W-1:0]  led_ff, led_in;
   logic [1:0]        part_ff, part_in;

   // Fill sweep
   logic [LED_W-1:0]   fill_addr_ff, fill_addr_in;
   logic [LED_W-1:0]   fill_last_ff, fill_last_in;
   logic [PIXEL_W-1:0] fill_data_ff, fill_data_in;

   logic [N_W-1:0]    n;
   logic [BYTE_W-1:0] n3;
   logic [15:0]       tick_next;
   logic [7:0]        dur_raw;
   logic [7:0]        bit_dur;
   logic [15:0]       gap_dur;
   logic [7:0]        next_byte;
   logic [PIXEL_W-1:0] req_pixel;

   assign n = (cfg.led_count > 9'(MAX_LEDS)) ? N_W'(MAX_LEDS) : N_W'(cfg.led_count);
   assign n3 = BYTE_W'({n, 1'b0}) + BYTE_W'(n);
   assign tick_next = tick_ff + 16'd1;
   assign req_pixel = {req_green, req_red, req_blue};
   assign rd_word = rd_valid_ff ? rd_data_ff : '0;
   assign rd_addr = cmd.load_first ? '0 : led_ff + LED_W'(1);

   always_comb begin
      if (low_ff) begin
         dur_raw = shift_ff[7] ? cfg.one_low : cfg.zero_low;
      end else begin
         dur_raw = shift_ff[7] ? cfg.one_high : cfg.zero_high;
      end
      bit_dur = (dur_raw == 8'd0) ? 8'd1 : dur_raw;
      gap_dur = (cfg.gap == 16'd0) ? 16'd1 : cfg.gap;
   end

   always_comb begin
      case (part_ff)
         PART_GREEN: next_byte = cur_ff[15:8];
         PART_RED:   next_byte = cur_ff[7:0];
         default:    next_byte = rd_word[23:16];
      endcase
   end

   assign status.sending   = sending_ff;
   assign status.n_zero    = (n == '0);
   assign status.fill_last = (fill_addr_ff == fill_last_ff);

   always_comb begin
      sending_in   = sending_ff;
      gap_in       = gap_ff;
      byte_in      = byte_ff;
      bit_in       = bit_ff;
      low_in       = low_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      cur_in       = cur_ff;
      led_in       = led_ff;
      part_in      = part_ff;
      fill_addr_in = fill_addr_ff;
      fill_last_in = fill_last_ff;
      fill_data_in = fill_data_ff;
      wr_en        = 1'b0;
      wr_addr      = LED_W'(req_pixel_index);
      wr_data      = req_pixel;
      valid_clr    = 1'b0;
      res          = '0;

      if (cmd.take_item) begin
         if (req_mode == MODE_TICK) begin
            if (sending_ff) begin
               res.busy_res = 1'b1;
               if (gap_ff) begin
                  if (tick_next >= gap_dur) begin
                     res.frame_done = 1'b1;
                     sending_in     = 1'b0;
                     gap_in         = 1'b0;
                     tick_in        = '0;
                  end else begin
                     tick_in = tick_next;
                  end
               end else begin
                  res.line_level = !low_ff;
                  if (tick_next >= {8'd0, bit_dur}) begin
                     tick_in = '0;
                     if (!low_ff) begin
                        low_in = 1'b1;
                     end else begin
                        low_in   = 1'b0;
                        shift_in = {shift_ff[6:0], 1'b0};
                        bit_in   = bit_ff + 3'd1;
                        if (bit_ff == 3'd7) begin
                           byte_in = byte_ff + BYTE_W'(1);
                           if (byte_in >= n3) begin
                              gap_in = 1'b1;
                           end else begin
                              shift_in = next_byte;
                           end
                           if (part_ff == PART_BLUE) begin
                              part_in = PART_GREEN;
                              led_in  = led_ff + LED_W'(1);
                              cur_in  = rd_word;
                           end else begin
                              part_in = part_ff + 2'd1;
                           end
                        end
                     end
                  end else begin
                     tick_in = tick_next;
                  end
               end
            end
         end else if (req_mode > MODE_SHOW || sending_ff) begin
            res.rejected = 1'b1;
         end else begin
            case (req_mode)
               MODE_SET: begin
                  if (N_W'(req_pixel_index) < n) begin
                     wr_en = 1'b1;
                  end else begin
                     res.rejected = 1'b1;
                  end
               end
               MODE_FILL: begin
                  fill_addr_in = '0;
                  fill_last_in = LED_W'(n - N_W'(1));
                  fill_data_in = req_pixel;
               end
               MODE_CLEAR: valid_clr = 1'b1;
               MODE_SHOW: begin
                  sending_in = 1'b1;
                  gap_in     = (n == '0);
                  byte_in    = '0;
                  bit_in     = '0;
                  low_in     = 1'b0;
                  tick_in    = '0;
                  led_in     = '0;
                  part_in    = PART_GREEN;
               end
               default: res.rejected = 1'b1;
            endcase
         end
         res.busy_res = res.busy_res | sending_in;
      end

      if (cmd.load_pixel) begin
         cur_in   = rd_word;
         shift_in = rd_word[23:16];
      end

      if (cmd.fill_step) begin
         wr_en        = 1'b1;
         wr_addr      = fill_addr_ff;
         wr_data      = fill_data_ff;
         fill_addr_in = fill_addr_ff + LED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= store_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (valid_clr) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         gap_ff     <= 1'b0;
         byte_ff    <= '0;
         bit_ff     <= '0;
         low_ff     <= 1'b0;
         tick_ff    <= '0;
         led_ff     <= '0;
         part_ff    <= PART_GREEN;
      end else begin
         sending_ff <= sending_in;
         gap_ff     <= gap_in;
         byte_ff    <= byte_in;
         bit_ff     <= bit_in;
         low_ff     <= low_in;
         tick_ff    <= tick_in;
         led_ff     <= led_in;
         part_ff    <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      cur_ff       <= cur_in;
      fill_addr_ff <= fill_addr_in;
      fill_last_ff <= fill_last_in;
      fill_data_ff <= fill_data_in;
   end

`ifndef SYNTH
   a_gap_in_frame: assert property (@(posedge clock) disable iff (reset)
      gap_ff |-> sending_ff)
      else $error("latch gap active outside a frame");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_item && res.frame_done) |-> (res.busy_res && !res.line_level))
      else $error("frame end reported with wrong level or busy");

   a_frame_end_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(sending_ff)) |-> $past(cmd.take_item && gap_ff))
      else $error("frame ended outside a gap tick");
`endif

endmodule

`default_nettype wire

/* src/rgb_led_pixel_serializer.sv */
// Top level of the addressable RGB LED line serializer with pixel store.
// Result: registered at acceptance and presented on the outputs in the cycle after.
// Acceptance: after tick, set pixel, clear and rejected commands the input stays ready;
// show passes the load-first and load-pixel states (store reads preload the first pixel);
// fill writes one store entry per cycle up to the led count; a full output slot stalls.
// Reset: synchronous; registers return to defaults and the store reads zero at once.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_pixel_serializer
   import rlps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [2:0]            req_mode,
   input  wire logic [7:0]            req_pixel_index,
   input  wire logic [7:0]            req_red,
   input  wire logic [7:0]            req_green,
   input  wire logic [7:0]            req_blue,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic                  rsp_line_level,
   output      logic                  rsp_busy_res,
   output      logic                  rsp_frame_done,
   output      logic                  rsp_rejected,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   result_type res;

   // Output register: one result per accepted transaction
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       out_free;

   // The output slot can take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   rlps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Controller gates acceptance during first-pixel preload, fill sweeps and a full output slot
   rlps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // Datapath computes the result of the accepted transaction combinationally
   rlps_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_mode        (req_mode),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .status          (status),
      .res             (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.take_item) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_ff.line_level;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_frame_done = rsp_ff.frame_done;
   assign rsp_rejected   = rsp_ff.rejected;

endmodule

`default_nettype wire

/* verif/rgb_led_pixel_serializer_test.sv */
// Self-checking testbench for the RGB LED line serializer: commands, waveform ticks, registers.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_pixel_serializer_test;
   import rlps_pkg::*;

   // Window of cycles in which neither side idles
   localparam int unsigned CALM_FROM   = 600;
   localparam int unsigned CALM_TO     = 900;
   // Long receiver stall, taken once while the request backlog is deep
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned HOLD_DEPTH  = 40;
   // Result shows in the cycle after acceptance; spare cycles at the end
   localparam int unsigned TAIL_CYCLES = 8;
   // Ticks pushed per round while flushing a frame
   localparam int unsigned FLUSH_CHUNK = 8;
   localparam int unsigned RAND_PHASES = 3;
   localparam int unsigned PHASE_OPS   = 10;

   // One request transaction, as it sits in the backlog
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_cmd_type;

   // ---------------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ---------------------------------------------------------------------------
   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_mode        = MODE_TICK;
   logic [7:0]            req_pixel_index = '0;
   logic [7:0]            req_red         = '0;
   logic [7:0]            req_green       = '0;
   logic [7:0]            req_blue        = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic                  rsp_line_level;
   logic                  rsp_busy_res;
   logic                  rsp_frame_done;
   logic                  rsp_rejected;
   logic                  csr_psel        = 1'b0;
   logic                  csr_penable     = 1'b0;
   logic                  csr_pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr       = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata      = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rgb_led_pixel_serializer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_pixel_index (req_pixel_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_level  (rsp_line_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_rejected    (rsp_rejected),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Line predictor: own copy of the registers, the pixel store and the
   // serializer position. Advanced once per accepted request transaction.
   // ---------------------------------------------------------------------------
   cfg_type            line_cfg;
   logic [PIXEL_W-1:0] pixel_mirror [MAX_LEDS];
   logic               tx_active;
   logic               tx_in_gap;
   logic               tx_low_half;
   int unsigned        tx_byte_pos;
   logic [2:0]         tx_bit_pos;
   int unsigned        tx_ticks;
   logic [7:0]         tx_shift;

   pixel_cmd_type      cmd_backlog [$];     // waiting to be driven
   result_type         line_expect_q [$];   // predicted results, oldest first

   int unsigned        errors       = 0;
   int unsigned        sent_count   = 0;
   int unsigned        result_count = 0;
   int unsigned        frames_done  = 0;
   int unsigned        reject_count = 0;
   int unsigned        cycle_count  = 0;
   logic               calm;

   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   // Oversized counts saturate at the store depth
   function automatic int unsigned leds_active();
      return (line_cfg.led_count > MAX_LEDS) ? MAX_LEDS : line_cfg.led_count;
   endfunction

   // A zero duration register behaves as one tick
   function automatic int unsigned floor_one(input int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   // Byte pos of the frame: per LED green, red, blue
   function automatic logic [7:0] chain_byte(input int unsigned pos);
      int unsigned led;
      led = pos / 3;
      if (led >= MAX_LEDS)
         return 8'h00;
      return 8'(pixel_mirror[led] >> (16 - 8 * (pos % 3)));
   endfunction

   function automatic void reset_mirror();
      line_cfg = '{led_count: RST_LED_COUNT, zero_high: RST_ZERO_HIGH,
                   zero_low: RST_ZERO_LOW, one_high: RST_ONE_HIGH,
                   one_low: RST_ONE_LOW, gap: RST_GAP};
      foreach (pixel_mirror[i])
         pixel_mirror[i] = '0;
      tx_active   = 1'b0;
      tx_in_gap   = 1'b0;
      tx_low_half = 1'b0;
      tx_byte_pos = 0;
      tx_bit_pos  = '0;
      tx_ticks    = 0;
      tx_shift    = '0;
   endfunction

   // Result for one transaction; updates the predictor state
   function automatic result_type advance_line(input pixel_cmd_type c);
      result_type  r;
      int unsigned n;
      int unsigned dur;
      logic        one;
      r = '0;
      n = leds_active();
      if (c.mode == MODE_TICK) begin
         if (tx_active) begin
            r.busy_res = 1'b1;
            if (tx_in_gap) begin
               tx_ticks++;
               if (tx_ticks >= floor_one(line_cfg.gap)) begin
                  r.frame_done = 1'b1;
                  tx_active    = 1'b0;
                  tx_in_gap    = 1'b0;
                  tx_ticks     = 0;
               end
            end else begin
               one = tx_shift[7];
               if (tx_low_half)
                  dur = one ? line_cfg.one_low : line_cfg.zero_low;
               else
                  dur = one ? line_cfg.one_high : line_cfg.zero_high;
               r.line_level = !tx_low_half;
               tx_ticks++;
               if (tx_ticks >= floor_one(dur)) begin
                  tx_ticks = 0;
                  if (!tx_low_half) begin
                     tx_low_half = 1'b1;
                  end else begin
                     // bit done: next bit, maybe next byte, maybe the gap
                     tx_low_half = 1'b0;
                     tx_shift    = tx_shift << 1;
                     tx_bit_pos  = tx_bit_pos + 3'd1;
                     if (tx_bit_pos == 3'd0) begin
                        tx_byte_pos++;
                        if (tx_byte_pos >= n * 3)
                           tx_in_gap = 1'b1;
                        else
                           tx_shift = chain_byte(tx_byte_pos);
                     end
                  end
               end
            end
         end
      end else if (c.mode > MODE_SHOW || tx_active) begin
         // unknown codes and any command during a frame
         r.rejected = 1'b1;
      end else if (c.mode == MODE_SET) begin
         if (c.index >= n)
            r.rejected = 1'b1;
         else
            pixel_mirror[c.index] = {c.green, c.red, c.blue};
      end else if (c.mode == MODE_FILL) begin
         for (int unsigned i = 0; i < n; i++)
            pixel_mirror[i] = {c.green, c.red, c.blue};
      end else if (c.mode == MODE_CLEAR) begin
         // the whole store, not only the entries in use
         foreach (pixel_mirror[i])
            pixel_mirror[i] = '0;
      end else begin
         tx_active   = 1'b1;
         tx_in_gap   = (n == 0);
         tx_byte_pos = 0;
         tx_bit_pos  = '0;
         tx_low_half = 1'b0;
         tx_ticks    = 0;
         tx_shift    = chain_byte(0);
      end
      if (c.mode != MODE_TICK)
         r.busy_res = tx_active;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: acceptance sampled at the rising edge, payload changed at
   // the falling edge. valid stays up with a stable payload until accepted.
   // ---------------------------------------------------------------------------
   logic          req_took = 1'b0;
   pixel_cmd_type pending_cmd;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_took = 1'b0;
      if (!reset && req_valid && req_ready) begin
         req_took = 1'b1;
         sent_count++;
         line_expect_q.push_back(advance_line({req_mode, req_pixel_index, req_red,
                                               req_green, req_blue}));
      end
   end

   always @(negedge clock) begin
      if (!req_valid || req_took) begin
         if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
            pending_cmd = cmd_backlog.pop_front();
            req_valid       <= 1'b1;
            req_mode        <= pending_cmd.mode;
            req_pixel_index <= pending_cmd.index;
            req_red         <= pending_cmd.red;
            req_green       <= pending_cmd.green;
            req_blue        <= pending_cmd.blue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: each accepted result is checked against the oldest
   // prediction. ready is driven at the falling edge, with one long stall.
   // ---------------------------------------------------------------------------
   result_type  want_res;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %b, got %b", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (rsp_frame_done === 1'b1)
            frames_done++;
         if (rsp_rejected === 1'b1)
            reject_count++;
         if (line_expect_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got level=%b busy=%b done=%b rej=%b",
                     $time, rsp_line_level, rsp_busy_res, rsp_frame_done, rsp_rejected);
            errors++;
         end else begin
            want_res = line_expect_q.pop_front();
            check_field("line_level", want_res.line_level, rsp_line_level);
            check_field("busy_res",   want_res.busy_res,   rsp_busy_res);
            check_field("frame_done", want_res.frame_done, rsp_frame_done);
            check_field("rejected",   want_res.rejected,   rsp_rejected);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && cmd_backlog.size() > HOLD_DEPTH) begin
         // back-pressure long enough for the block to fill and stall its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 32);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // APB write (setup + access) followed by a read-back of the same register
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [CSR_DATA_W-1:0] mask;
      case (idx)
         REG_LED_COUNT: mask = 32'h1FF;
         REG_GAP:       mask = 32'hFFFF;
         default:       mask = 32'hFF;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      case (idx)
         REG_LED_COUNT: line_cfg.led_count = value[8:0];
         REG_ZERO_HIGH: line_cfg.zero_high = value[7:0];
         REG_ZERO_LOW:  line_cfg.zero_low  = value[7:0];
         REG_ONE_HIGH:  line_cfg.one_high  = value[7:0];
         REG_ONE_LOW:   line_cfg.one_low   = value[7:0];
         REG_GAP:       line_cfg.gap       = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if ((csr_prdata & mask) !== (value & mask)) begin
         $display("%0t: register %0d read-back: expected %h, got %h",
                  $time, idx, value & mask, csr_prdata & mask);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_cmd(input logic [2:0] mode, input logic [7:0] idx,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      cmd_backlog.push_back({mode, idx, r, g, b});
   endtask

   // Tick transactions carry random junk in the unused fields
   task automatic queue_ticks(input int unsigned count);
      repeat (count)
         queue_cmd(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Sender pause: nothing queued, nothing on the bus, nothing owed, input ready
   task automatic wait_quiet();
      @(posedge clock);
      while (cmd_backlog.size() != 0 || req_valid || line_expect_q.size() != 0 || !req_ready)
         @(posedge clock);
   endtask

   // Drain, then tick out whatever frame is still on the line
   task automatic settle_line();
      wait_quiet();
      while (tx_active) begin
         queue_ticks(FLUSH_CHUNK);
         wait_quiet();
      end
   endtask

   // Tick a running frame until its data is out and the latch gap has begun
   task automatic tick_to_gap();
      wait_quiet();
      while (tx_active && !tx_in_gap) begin
         queue_ticks(FLUSH_CHUNK);
         wait_quiet();
      end
   endtask

   // Non-show command or a short burst of ticks
   task automatic queue_random_cmd();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  idx;
      n    = leds_active();
      pick = $urandom_range(99);
      if (pick < 45) begin
         // mostly in range, the edge index n included; sometimes anywhere
         if ($urandom_range(4) == 0)
            idx = 8'($urandom_range(255));
         else
            idx = 8'($urandom_range((n < 255) ? n : 255));
         queue_cmd(MODE_SET, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 55) begin
         queue_cmd(MODE_FILL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 60) begin
         queue_cmd(MODE_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 66) begin
         queue_cmd(MODE_SHOW + 3'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
      end else begin
         queue_ticks($urandom_range(1, 4));
      end
   endtask

   // Show plus ticks: usually the whole frame, sometimes cut short, with stray
   // commands mixed in (rejected while the frame runs)
   task automatic queue_frame();
      int unsigned bit_span;
      int unsigned span;
      int unsigned count;
      bit_span = floor_one(line_cfg.zero_high) + floor_one(line_cfg.zero_low);
      if (floor_one(line_cfg.one_high) + floor_one(line_cfg.one_low) > bit_span)
         bit_span = floor_one(line_cfg.one_high) + floor_one(line_cfg.one_low);
      span = leds_active() * 24 * bit_span + floor_one(line_cfg.gap) + 2;
      queue_cmd(MODE_SHOW, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      count = ($urandom_range(3) != 0) ? span + $urandom_range(8) : $urandom_range(span);
      repeat (count) begin
         if ($urandom_range(15) == 0)
            queue_random_cmd();
         else
            queue_ticks(1);
      end
   endtask

   // Random settings: short chains and short waveforms
   task automatic run_random_phase(input int unsigned ops);
      write_reg(REG_LED_COUNT, ($urandom_range(9) == 0) ? $urandom_range(2, 3)
                                                        : $urandom_range(1));
      write_reg(REG_ZERO_HIGH, $urandom_range(2));
      write_reg(REG_ZERO_LOW,  $urandom_range(2));
      write_reg(REG_ONE_HIGH,  $urandom_range(2));
      write_reg(REG_ONE_LOW,   $urandom_range(2));
      write_reg(REG_GAP,       $urandom_range(4));
      repeat (ops) begin
         if ($urandom_range(99) < 12)
            queue_frame();
         else
            queue_random_cmd();
      end
      settle_line();
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset_mirror();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings but a short gap, empty chain: idle tick, set with no LEDs,
      // unknown codes, show that sends only the gap, then every command while busy
      write_reg(REG_GAP, 3);
      queue_cmd(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_cmd(MODE_SET, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      queue_cmd(MODE_SHOW + 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00);
      queue_cmd(MODE_SHOW + 3'd2, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      queue_cmd(MODE_SHOW + 3'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_cmd(MODE_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_cmd(MODE_SET, 8'h00, 8'h12, 8'h34, 8'h56);
      queue_cmd(MODE_FILL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      queue_cmd(MODE_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_cmd(MODE_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
      settle_line();

      // Two LEDs, zero durations standing in for one tick, zero gap; the frame's
      // ticks go in as one deep backlog so the receiver stall backs up the input
      write_reg(REG_LED_COUNT, 2);
      write_reg(REG_ZERO_HIGH, 0);
      write_reg(REG_ZERO_LOW,  1);
      write_reg(REG_ONE_HIGH,  2);
      write_reg(REG_ONE_LOW,   0);
      write_reg(REG_GAP,       0);
      queue_cmd(MODE_FILL, 8'h00, 8'h00, 8'hFF, 8'h00);
      queue_cmd(MODE_SET, 8'h01, 8'hA5, 8'h5A, 8'hFF);
      queue_cmd(MODE_SET, 8'h02, 8'h11, 8'h22, 8'h33);   // index == count: out of range
      queue_cmd(MODE_SET, 8'hFF, 8'h44, 8'h55, 8'h66);
      queue_cmd(MODE_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_ticks(120);
      settle_line();

      // Oversized count saturates at the full store, fastest waveform; the chain
      // is cut to nothing mid-frame, so the gap starts at the next byte end
      write_reg(REG_LED_COUNT, 511);
      write_reg(REG_ZERO_HIGH, 1);
      write_reg(REG_ZERO_LOW,  1);
      write_reg(REG_ONE_HIGH,  1);
      write_reg(REG_ONE_LOW,   1);
      write_reg(REG_GAP,       1);
      queue_cmd(MODE_FILL, 8'h00, 8'h81, 8'h7E, 8'hC3);
      queue_cmd(MODE_SET, 8'hFF, 8'h00, 8'hFF, 8'h01);
      queue_cmd(MODE_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_ticks(20);
      wait_quiet();
      write_reg(REG_LED_COUNT, 0);
      settle_line();

      // Clear with no LED in use must still wipe the store
      write_reg(REG_LED_COUNT, 0);
      queue_cmd(MODE_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_quiet();
      write_reg(REG_LED_COUNT, 1);
      queue_cmd(MODE_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
      settle_line();

      // Longest durations and gap, shortened mid-bit and mid-gap
      write_reg(REG_LED_COUNT, 1);
      write_reg(REG_ZERO_HIGH, 255);
      write_reg(REG_ZERO_LOW,  255);
      write_reg(REG_ONE_HIGH,  255);
      write_reg(REG_ONE_LOW,   255);
      write_reg(REG_GAP,       65535);
      queue_cmd(MODE_SET, 8'h00, 8'h0F, 8'hF0, 8'h99);
      queue_cmd(MODE_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_ticks(3);
      wait_quiet();
      write_reg(REG_ZERO_HIGH, 1);
      write_reg(REG_ZERO_LOW,  1);
      write_reg(REG_ONE_HIGH,  1);
      write_reg(REG_ONE_LOW,   1);
      tick_to_gap();
      queue_ticks(4);
      wait_quiet();
      write_reg(REG_GAP, 2);
      settle_line();

      repeat (RAND_PHASES)
         run_random_phase(PHASE_OPS);

      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request transactions and %0d checked results:", sent_count,
               result_count);
      $display("%0d frames closed, %0d commands rejected, %0d errors.", frames_done,
               reject_count, errors);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("%0t: timeout with %0d results still owed", $time, line_expect_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
